// ----- rtl/core/eqrs_pkg.sv -----
package eqrs_pkg;

	localparam int EQRS_FIFO_DEPTH = 8;
	localparam int EQRS_INFO_LIMIT = 6;

	// operation codes
	localparam logic [1:0] OP_POST     = 2'd0;
	localparam logic [1:0] OP_POP      = 2'd1;
	localparam logic [1:0] OP_SNAPSHOT = 2'd2;

	// register indexes
	localparam logic [1:0] REG_ENABLE_MASK   = 2'd0;
	localparam logic [1:0] REG_CRITICAL_MASK = 2'd1;
	localparam logic [1:0] REG_FAULT_TYPE    = 2'd2;
	localparam logic [1:0] REG_STALL_TYPE    = 2'd3;

	// status word bits decoded by a snapshot
	localparam int ST_READY_BIT   = 13;
	localparam int ST_ARMED_BIT   = 9;
	localparam int ST_MODE_HI_BIT = 12;
	localparam int ST_RUN0_BIT    = 14;
	localparam int ST_RUN1_BIT    = 15;

	typedef struct packed {
		logic [1:0]  operation;
		logic [2:0]  event_type;
		logic [15:0] status_word;
	} eqrs_cmd_t;

	typedef struct packed {
		logic [1:0]  accepted_count;
		logic        pop_valid;
		logic [2:0]  popped_type;
		logic [15:0] popped_status;
		logic [31:0] sent_total;
		logic [31:0] lost_critical_total;
		logic [31:0] lost_info_total;
		logic [3:0]  fill_level;
	} eqrs_rsp_t;

	typedef struct packed {
		logic [7:0] enable_mask;
		logic [7:0] critical_mask;
		logic [2:0] fault_type_code;
		logic [2:0] stall_type_code;
	} eqrs_cfg_t;

	typedef struct packed {
		logic [2:0]  evt_type;
		logic [15:0] status;
	} eqrs_entry_t;

	typedef struct packed {
		logic       shift;
		logic       load;
		logic [2:0] load_type;
	} eqrs_cell_ctl_t;

	// admission decision for one command; second write lands after the first
	typedef struct packed {
		logic       wr0_en;
		logic [2:0] wr0_type;
		logic       wr1_en;
		logic [2:0] wr1_type;
		logic [1:0] accepted;
		logic [1:0] lost_crit_inc;
		logic [1:0] lost_info_inc;
	} eqrs_adm_t;

endpackage

// ----- rtl/core/event_queue_reserved_slots.sv -----
// Event queue with reserved slots.
// Command channel (cmd_valid/cmd_stall/cmd) carries one word per operation:
// post an event, pop the oldest event, or decode a status snapshot that
// posts a fault and/or a stall event. Each command yields exactly one word
// on the response channel (rsp_valid/rsp_stall/rsp) with the accepted
// count, the popped event and the running counters and fill level.
// The response is registered: a command taken at an edge shows its response
// after that edge. Throughput is one command per cycle while the receiver does
// not stall, set by the response register; every command, a two-event snapshot
// too, needs no extra states because the storage is a row of cells that load
// at the fill position and shift toward the head on a pop.
// While the receiver stalls a waiting response, cmd_stall is raised and the
// response word holds.
// Reset clears the fill level, the counters and the response valid and sets
// the registers to enable none, critical types 0 and 1, fault type 0 and
// stall type 1. Stored events are not cleared; only filled cells are read.
// Configuration writes (cfg_write/cfg_index/cfg_data) take effect at once.
module event_queue_reserved_slots
	import eqrs_pkg::*;
#(
	parameter int FIFO_DEPTH = EQRS_FIFO_DEPTH,
	parameter int INFO_LIMIT = EQRS_INFO_LIMIT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_stall,
	input  eqrs_cmd_t  cmd,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output eqrs_rsp_t  rsp,
	input  logic       cfg_write,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	localparam int OCC_W = $clog2(FIFO_DEPTH + 1);

	eqrs_cfg_t        cfg_q;
	logic [OCC_W-1:0] occ_q, occ_d;
	logic [31:0]      sent_q, sent_d;
	logic [31:0]      lost_crit_q, lost_crit_d;
	logic [31:0]      lost_info_q, lost_info_d;
	logic             rsp_valid_q;
	eqrs_rsp_t        rsp_q, rsp_d;

	logic             cmd_fire;
	logic             pop_go;
	logic             wr0, wr1;
	logic [OCC_W:0]   slot0, slot1;
	logic [OCC_W+3:0] occ_ext;
	eqrs_adm_t        adm;

	eqrs_entry_t      cell_q [FIFO_DEPTH];
	eqrs_cell_ctl_t   cell_ctl [FIFO_DEPTH];

	// hold the command side while a response waits
	assign cmd_stall = rsp_valid_q && rsp_stall;
	assign cmd_fire  = cmd_valid && !cmd_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable_mask     <= 8'h00;
			cfg_q.critical_mask   <= 8'h03;
			cfg_q.fault_type_code <= 3'd0;
			cfg_q.stall_type_code <= 3'd1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_ENABLE_MASK:   cfg_q.enable_mask     <= cfg_data;
				REG_CRITICAL_MASK: cfg_q.critical_mask   <= cfg_data;
				REG_FAULT_TYPE:    cfg_q.fault_type_code <= cfg_data[2:0];
				REG_STALL_TYPE:    cfg_q.stall_type_code <= cfg_data[2:0];
				default: begin
				end
			endcase
		end
	end

	eqrs_admit #(
		.FIFO_DEPTH (FIFO_DEPTH),
		.INFO_LIMIT (INFO_LIMIT),
		.OCC_W      (OCC_W)
	) u_admit (
		.cmd (cmd),
		.cfg (cfg_q),
		.occ (occ_q),
		.adm (adm)
	);

	// a pop on an empty queue changes nothing
	assign pop_go = cmd_fire && (cmd.operation == OP_POP) && (occ_q != '0);
	assign wr0    = cmd_fire && adm.wr0_en;
	assign wr1    = cmd_fire && adm.wr1_en;

	// first accepted event lands at the fill position, the second right after it
	assign slot0 = {1'b0, occ_q};
	assign slot1 = {1'b0, occ_q} + (OCC_W+1)'(adm.wr0_en);

	// row of cells: cell 0 is the head, each cell shifts in its upper neighbor
	for (genvar gi = 0; gi < FIFO_DEPTH; gi++) begin : g_cell
		eqrs_entry_t nb;
		logic        hit0, hit1;

		if (gi == FIFO_DEPTH - 1) begin : g_last
			assign nb = cell_q[gi];
		end else begin : g_mid
			assign nb = cell_q[gi+1];
		end

		assign hit0 = wr0 && (slot0 == (OCC_W+1)'(gi));
		assign hit1 = wr1 && (slot1 == (OCC_W+1)'(gi));

		assign cell_ctl[gi].shift     = pop_go;
		assign cell_ctl[gi].load      = hit0 || hit1;
		assign cell_ctl[gi].load_type = hit0 ? adm.wr0_type : adm.wr1_type;

		eqrs_cell u_cell (
			.clk      (clk),
			.ctl      (cell_ctl[gi]),
			.status   (cmd.status_word),
			.neighbor (nb),
			.entry    (cell_q[gi])
		);
	end

	// advance fill level and counters for the accepted command
	always_comb begin
		occ_d       = occ_q;
		sent_d      = sent_q;
		lost_crit_d = lost_crit_q;
		lost_info_d = lost_info_q;
		if (cmd_fire) begin
			occ_d       = occ_q - OCC_W'(pop_go) + OCC_W'(adm.wr0_en) + OCC_W'(adm.wr1_en);
			sent_d      = sent_q + 32'(adm.accepted);
			lost_crit_d = lost_crit_q + 32'(adm.lost_crit_inc);
			lost_info_d = lost_info_q + 32'(adm.lost_info_inc);
		end
	end

	assign occ_ext = {4'b0000, occ_d};

	always_comb begin
		rsp_d.accepted_count      = adm.accepted;
		rsp_d.pop_valid           = pop_go;
		rsp_d.popped_type         = pop_go ? cell_q[0].evt_type : 3'd0;
		rsp_d.popped_status       = pop_go ? cell_q[0].status : 16'd0;
		rsp_d.sent_total          = sent_d;
		rsp_d.lost_critical_total = lost_crit_d;
		rsp_d.lost_info_total     = lost_info_d;
		rsp_d.fill_level          = occ_ext[3:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			sent_q      <= '0;
			lost_crit_q <= '0;
			lost_info_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			occ_q       <= occ_d;
			sent_q      <= sent_d;
			lost_crit_q <= lost_crit_d;
			lost_info_q <= lost_info_d;
			if (cmd_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response word: load on a new command, hold otherwise
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- rtl/core/eqrs_cell.sv -----
module eqrs_cell
	import eqrs_pkg::*;
(
	input  logic           clk,
	input  eqrs_cell_ctl_t ctl,
	input  logic [15:0]    status,
	input  eqrs_entry_t    neighbor,
	output eqrs_entry_t    entry
);

	eqrs_entry_t entry_q;

	// load wins over shift; a command never does both
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			entry_q.evt_type <= ctl.load_type;
			entry_q.status   <= status;
		end else if (ctl.shift) begin
			entry_q <= neighbor;
		end
	end

	assign entry = entry_q;

endmodule

// ----- rtl/core/eqrs_admit.sv -----
module eqrs_admit
	import eqrs_pkg::*;
#(
	parameter int FIFO_DEPTH = EQRS_FIFO_DEPTH,
	parameter int INFO_LIMIT = EQRS_INFO_LIMIT,
	parameter int OCC_W      = $clog2(FIFO_DEPTH + 1)
) (
	input  eqrs_cmd_t        cmd,
	input  eqrs_cfg_t        cfg,
	input  logic [OCC_W-1:0] occ,
	output eqrs_adm_t        adm
);

	typedef struct packed {
		logic take;
		logic lost_crit;
		logic lost_info;
	} offer_t;

	function automatic offer_t offer(input logic [2:0] typ, input logic [31:0] fill,
			input eqrs_cfg_t c);
		offer_t r;
		logic   crit;
		r    = '0;
		crit = c.critical_mask[typ];
		if (c.enable_mask[typ]) begin
			if (!crit && fill >= 32'(INFO_LIMIT)) begin
				r.lost_info = 1'b1;
			end else if (fill >= 32'(FIFO_DEPTH)) begin
				r.lost_crit = crit;
				r.lost_info = !crit;
			end else begin
				r.take = 1'b1;
			end
		end
		return r;
	endfunction

	logic       fault, stall;
	logic       want0, want1;
	logic [2:0] type0, type1;
	offer_t     o0, o1;

	always_comb begin
		fault = !cmd.status_word[ST_READY_BIT] || !cmd.status_word[ST_ARMED_BIT]
			|| cmd.status_word[ST_MODE_HI_BIT];
		stall = !cmd.status_word[ST_RUN0_BIT] || !cmd.status_word[ST_RUN1_BIT];
		want0 = 1'b0;
		want1 = 1'b0;
		type0 = cmd.event_type;
		type1 = cfg.stall_type_code;
		unique case (cmd.operation)
			OP_POST: begin
				want0 = 1'b1;
			end
			OP_SNAPSHOT: begin
				want0 = fault;
				type0 = cfg.fault_type_code;
				want1 = stall;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		o0 = want0 ? offer(type0, 32'(occ), cfg) : '0;
		o1 = want1 ? offer(type1, 32'(occ) + 32'(o0.take), cfg) : '0;
		adm.wr0_en        = o0.take;
		adm.wr0_type      = type0;
		adm.wr1_en        = o1.take;
		adm.wr1_type      = type1;
		adm.accepted      = 2'(o0.take) + 2'(o1.take);
		adm.lost_crit_inc = 2'(o0.lost_crit) + 2'(o1.lost_crit);
		adm.lost_info_inc = 2'(o0.lost_info) + 2'(o1.lost_info);
	end

endmodule

// ----- rtl/core/eqrs_checker.sv -----
module eqrs_checker
	import eqrs_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_valid,
	input logic       cmd_stall,
	input logic       rsp_valid,
	input logic       rsp_stall,
	input eqrs_rsp_t  rsp
);

	// a stalled response word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response word changed under stall");

	// every accepted command yields a response in the next cycle
	a_cmd_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> rsp_valid)
		else $error("accepted command gave no response");

	// no pop data without a successful pop
	a_pop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.pop_valid |-> rsp.popped_type == 3'd0 && rsp.popped_status == 16'd0)
		else $error("pop fields nonzero without pop");

	// a pop never enqueues, and a command enqueues at most two events
	a_pop_vs_post: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.pop_valid && rsp.accepted_count != 2'd0)
			&& rsp.accepted_count != 2'd3)
		else $error("bad accepted count");

endmodule

bind event_queue_reserved_slots eqrs_checker u_eqrs_checker (.*);

// ----- tb/sv/tb_event_queue_reserved_slots.sv -----
module tb_event_queue_reserved_slots;
	import eqrs_pkg::*;

	// Code 3 is not an operation; the block must answer it without touching state.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int DIR_ROWS     = 27;
	localparam int DIR_CFG_ROW  = 4;
	localparam int SQUEEZE_LEN  = 60;
	localparam int NUM_PHASES   = 6;
	localparam int MAX_REPORTS  = 30;

	// Setting used by the directed part after the reset checks: every type on,
	// types 0 and 7 critical, fault posts type 0 (critical), stall posts type 1 (info).
	localparam eqrs_cfg_t DIR_CFG = '{8'hFF, 8'h81, 3'd0, 3'd1};

	typedef struct {
		bit         has_literal;
		eqrs_cmd_t  cmd_word;
		eqrs_rsp_t  rsp_word;
	} dir_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cmd_valid = 1'b0;
	logic       cmd_stall;
	eqrs_cmd_t  cmd = '0;
	logic       rsp_valid;
	logic       rsp_stall = 1'b0;
	eqrs_rsp_t  rsp;
	logic       cfg_write = 1'b0;
	logic [1:0] cfg_index = REG_ENABLE_MASK;
	logic [7:0] cfg_data = '0;

	// Side information that travels with the command word: a directed row whose
	// answer is typed in carries it here, so the monitor can queue it.
	bit         cmd_literal = 1'b0;
	eqrs_rsp_t  cmd_literal_rsp = '0;

	int         idle_pct = 0;
	int         stall_pct = 0;
	bit         squeeze_on = 1'b0;
	int         squeeze_cycles = 0;

	int         fail_count = 0;
	int         n_cmds = 0;
	int         n_rsps = 0;
	int         n_popped = 0;
	int         held_off_cycles = 0;
	int         max_fill = 0;

	eqrs_rsp_t  pending_rsp [$];

	// Shadow of the queue: stored events, pointers, fill level, counters, registers.
	eqrs_entry_t held_events [EQRS_FIFO_DEPTH];
	int unsigned head_idx = 0;
	int unsigned tail_idx = 0;
	int unsigned held_count = 0;
	logic [31:0] sent_cnt = '0;
	logic [31:0] lost_crit_cnt = '0;
	logic [31:0] lost_info_cnt = '0;
	eqrs_cfg_t   shadow_cfg = '{8'h00, 8'h03, 3'd0, 3'd1};

	// Directed table. Rows with has_literal set carry the answer that can be read
	// off at a glance; the others are checked against the shadow queue.
	dir_row_t dir_rows [DIR_ROWS] = '{
		// reset setting: every type disabled, nothing moves
		'{1'b1, '{OP_POST,     3'd0, 16'hFFFF}, '{2'd0, 1'b0, 3'd0, 16'h0, 32'd0, 32'd0, 32'd0, 4'd0}},
		'{1'b1, '{OP_POP,      3'd0, 16'h0000}, '{2'd0, 1'b0, 3'd0, 16'h0, 32'd0, 32'd0, 32'd0, 4'd0}},
		'{1'b1, '{OP_SNAPSHOT, 3'd0, 16'h0000}, '{2'd0, 1'b0, 3'd0, 16'h0, 32'd0, 32'd0, 32'd0, 4'd0}},
		'{1'b1, '{OP_UNUSED,   3'd7, 16'hFFFF}, '{2'd0, 1'b0, 3'd0, 16'h0, 32'd0, 32'd0, 32'd0, 4'd0}},
		// all types enabled from here on
		'{1'b1, '{OP_POST,     3'd7, 16'hFFFF}, '{2'd1, 1'b0, 3'd0, 16'h0, 32'd1, 32'd0, 32'd0, 4'd1}},
		'{1'b1, '{OP_POST,     3'd2, 16'h0000}, '{2'd1, 1'b0, 3'd0, 16'h0, 32'd2, 32'd0, 32'd0, 4'd2}},
		// fault and stall both present
		'{1'b1, '{OP_SNAPSHOT, 3'd0, 16'h0000}, '{2'd2, 1'b0, 3'd0, 16'h0, 32'd4, 32'd0, 32'd0, 4'd4}},
		// healthy status: nothing posted
		'{1'b1, '{OP_SNAPSHOT, 3'd0, 16'hE200}, '{2'd0, 1'b0, 3'd0, 16'h0, 32'd4, 32'd0, 32'd0, 4'd4}},
		// fault from the mode field alone
		'{1'b0, '{OP_SNAPSHOT, 3'd0, 16'hF200}, '0},
		// fault lands first and takes the last info slot away from the stall
		'{1'b0, '{OP_SNAPSHOT, 3'd0, 16'h0000}, '0},
		// info post blocked by the reservation
		'{1'b0, '{OP_POST,     3'd3, 16'h1234}, '0},
		// stall alone, info type, reservation reached
		'{1'b0, '{OP_SNAPSHOT, 3'd0, 16'h6200}, '0},
		// fault from the armed bit alone
		'{1'b0, '{OP_SNAPSHOT, 3'd0, 16'hE000}, '0},
		'{1'b0, '{OP_POST,     3'd7, 16'h8001}, '0},
		// queue full: critical lost
		'{1'b0, '{OP_POST,     3'd0, 16'h7FFE}, '0},
		'{1'b0, '{OP_POST,     3'd5, 16'hAAAA}, '0},
		'{1'b0, '{OP_SNAPSHOT, 3'd7, 16'h0000}, '0},
		// oldest event comes out first
		'{1'b1, '{OP_POP,      3'd0, 16'h0000}, '{2'd0, 1'b1, 3'd7, 16'hFFFF, 32'd8, 32'd2, 32'd5, 4'd7}},
		'{1'b0, '{OP_POP,      3'd0, 16'h0000}, '0},
		'{1'b0, '{OP_POP,      3'd0, 16'h0000}, '0},
		'{1'b0, '{OP_POP,      3'd0, 16'h0000}, '0},
		'{1'b0, '{OP_POP,      3'd0, 16'h0000}, '0},
		'{1'b0, '{OP_POP,      3'd0, 16'h0000}, '0},
		'{1'b0, '{OP_POP,      3'd0, 16'h0000}, '0},
		'{1'b0, '{OP_POP,      3'd0, 16'h0000}, '0},
		// drained: pop on empty, then the unused code with live counters
		'{1'b1, '{OP_POP,      3'd0, 16'h0000}, '{2'd0, 1'b0, 3'd0, 16'h0, 32'd8, 32'd2, 32'd5, 4'd0}},
		'{1'b1, '{OP_UNUSED,   3'd0, 16'h0000}, '{2'd0, 1'b0, 3'd0, 16'h0, 32'd8, 32'd2, 32'd5, 4'd0}}
	};

	event_queue_reserved_slots DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Offer one event to the shadow queue; return 1 when it is stored.
	function automatic bit admit_event(logic [2:0] kind, logic [15:0] word_in);
		bit crit;
		if (!shadow_cfg.enable_mask[kind])
			return 1'b0;
		crit = shadow_cfg.critical_mask[kind];
		if (!crit && held_count >= EQRS_INFO_LIMIT) begin
			lost_info_cnt = lost_info_cnt + 32'd1;
			return 1'b0;
		end
		if (held_count >= EQRS_FIFO_DEPTH) begin
			if (crit)
				lost_crit_cnt = lost_crit_cnt + 32'd1;
			else
				lost_info_cnt = lost_info_cnt + 32'd1;
			return 1'b0;
		end
		held_events[tail_idx] = '{evt_type: kind, status: word_in};
		tail_idx = (tail_idx + 1) % EQRS_FIFO_DEPTH;
		held_count++;
		sent_cnt = sent_cnt + 32'd1;
		return 1'b1;
	endfunction

	// Advance the shadow queue by one command word and return the answer it owes.
	function automatic eqrs_rsp_t queue_step(eqrs_cmd_t c);
		eqrs_rsp_t   r;
		logic [15:0] s;
		bit          fault;
		bit          stall;
		r = '0;
		s = c.status_word;
		case (c.operation)
			OP_POST: begin
				r.accepted_count = 2'(admit_event(c.event_type, s));
			end
			OP_POP: begin
				if (held_count != 0) begin
					r.pop_valid = 1'b1;
					r.popped_type = held_events[head_idx].evt_type;
					r.popped_status = held_events[head_idx].status;
					head_idx = (head_idx + 1) % EQRS_FIFO_DEPTH;
					held_count--;
				end
			end
			OP_SNAPSHOT: begin
				if (shadow_cfg.enable_mask != 8'h00) begin
					// mode field of 2 or more means its upper bit is set
					fault = !s[ST_READY_BIT] || !s[ST_ARMED_BIT] || s[ST_MODE_HI_BIT];
					stall = !s[ST_RUN0_BIT] || !s[ST_RUN1_BIT];
					if (fault)
						r.accepted_count = r.accepted_count
							+ 2'(admit_event(shadow_cfg.fault_type_code, s));
					if (stall)
						r.accepted_count = r.accepted_count
							+ 2'(admit_event(shadow_cfg.stall_type_code, s));
				end
			end
			default: ;
		endcase
		r.sent_total = sent_cnt;
		r.lost_critical_total = lost_crit_cnt;
		r.lost_info_total = lost_info_cnt;
		r.fill_level = 4'(held_count);
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("mismatch on response %0d: %s", n_rsps, msg);
	endtask

	task automatic check_field(string field, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %0h, expected %0h", field, got, want));
	endtask

	// Monitor: apply register writes to the shadow, compare every response word
	// with the oldest expectation, then queue the expectation for a new command.
	// Compare before queueing so a response can never match its own command.
	always @(posedge clk) begin
		eqrs_rsp_t want;
		if (arst_n) begin
			if (cfg_write) begin
				case (cfg_index)
					REG_ENABLE_MASK:   shadow_cfg.enable_mask = cfg_data;
					REG_CRITICAL_MASK: shadow_cfg.critical_mask = cfg_data;
					REG_FAULT_TYPE:    shadow_cfg.fault_type_code = cfg_data[2:0];
					REG_STALL_TYPE:    shadow_cfg.stall_type_code = cfg_data[2:0];
					default: ;
				endcase
			end
			if (rsp_valid && !rsp_stall) begin
				n_rsps++;
				if (pending_rsp.size() == 0) begin
					report_mismatch("response word with no command outstanding");
				end else begin
					want = pending_rsp.pop_front();
					check_field("accepted_count", 32'(rsp.accepted_count),
						32'(want.accepted_count));
					check_field("pop_valid", 32'(rsp.pop_valid), 32'(want.pop_valid));
					check_field("popped_type", 32'(rsp.popped_type), 32'(want.popped_type));
					check_field("popped_status", 32'(rsp.popped_status),
						32'(want.popped_status));
					check_field("sent_total", rsp.sent_total, want.sent_total);
					check_field("lost_critical_total", rsp.lost_critical_total,
						want.lost_critical_total);
					check_field("lost_info_total", rsp.lost_info_total, want.lost_info_total);
					check_field("fill_level", 32'(rsp.fill_level), 32'(want.fill_level));
					if (rsp.pop_valid === 1'b1)
						n_popped++;
					if (int'(rsp.fill_level) > max_fill)
						max_fill = int'(rsp.fill_level);
				end
			end
			if (cmd_valid && cmd_stall)
				held_off_cycles++;
			if (cmd_valid && !cmd_stall) begin
				n_cmds++;
				want = queue_step(cmd);
				pending_rsp.push_back(cmd_literal ? cmd_literal_rsp : want);
			end
		end
	end

	// Receiver: random stall at the phase rate, except for one long hold-off
	// counted here while the sender keeps pushing.
	always @(posedge clk) begin
		if (squeeze_on && squeeze_cycles < SQUEEZE_LEN) begin
			rsp_stall <= 1'b1;
			squeeze_cycles <= squeeze_cycles + 1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Present one command word and hold it until the block takes it.
	task automatic send_word(eqrs_cmd_t c, bit literal, eqrs_rsp_t literal_rsp);
		cmd <= c;
		cmd_literal <= literal;
		cmd_literal_rsp <= literal_rsp;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
	endtask

	// Drop valid for a random number of cycles at the phase's idle rate.
	task automatic sender_pause();
		if ($urandom_range(99) < idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct)
				@(posedge clk);
		end
	endtask

	// Stop offering and wait until every expected response has been taken.
	task automatic drain();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	// Write all four registers on consecutive edges; junk in the unused upper
	// bits of the type codes must be ignored.
	task automatic write_config(eqrs_cfg_t v);
		cfg_write <= 1'b1;
		cfg_index <= REG_ENABLE_MASK;
		cfg_data <= v.enable_mask;
		@(posedge clk);
		cfg_index <= REG_CRITICAL_MASK;
		cfg_data <= v.critical_mask;
		@(posedge clk);
		cfg_index <= REG_FAULT_TYPE;
		cfg_data <= {5'($urandom), v.fault_type_code};
		@(posedge clk);
		cfg_index <= REG_STALL_TYPE;
		cfg_data <= {5'($urandom), v.stall_type_code};
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	initial begin
		#3_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		eqrs_cmd_t c;
		eqrs_cfg_t setting;
		int        n_items;
		int        pick;
		int        trend_left;
		bit        fill_trend;

		trend_left = 0;
		fill_trend = 1'b0;

		// Hold reset, then release it once and never again.
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed walk, no idling on either side.
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (i == DIR_CFG_ROW) begin
				drain();
				write_config(DIR_CFG);
			end
			send_word(dir_rows[i].cmd_word, dir_rows[i].has_literal, dir_rows[i].rsp_word);
		end
		drain();

		// Random phases: each picks a register setting, idle rates and a length.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: begin
					// everything informational: the reservation does all the dropping
					setting = '{8'hFF, 8'h00, 3'd7, 3'd0};
					idle_pct = 0;
					stall_pct <= 0;
					n_items = 120;
				end
				1: begin
					setting = '{8'hFF, 8'hFF, 3'd3, 3'd5};
					idle_pct = 55;
					stall_pct <= 0;
					n_items = 120;
				end
				3: begin
					// every type disabled: only pops and counters reported
					setting = '{8'h00, 8'hFF, 3'd0, 3'd7};
					idle_pct = 9;
					stall_pct <= 9;
					n_items = 30;
				end
				default: begin
					setting.enable_mask = 8'($urandom) | (8'h01 << $urandom_range(7));
					setting.critical_mask = 8'($urandom);
					setting.fault_type_code = 3'($urandom);
					setting.stall_type_code = 3'($urandom);
					idle_pct = (ph == 2 || ph == 4) ? 0 : 9;
					stall_pct <= (ph == 2) ? 55 : 9;
					n_items = (ph == 5) ? 160 : (ph == 4) ? 150 : 120;
				end
			endcase
			write_config(setting);
			// Long receiver hold-off with the sender pushing back to back.
			if (ph == 4)
				squeeze_on <= 1'b1;

			for (int k = 0; k < n_items; k++) begin
				// Alternate runs that fill the queue with runs that empty it.
				if (trend_left == 0) begin
					fill_trend = ~fill_trend;
					trend_left = $urandom_range(6, 20);
				end
				trend_left--;
				c.event_type = 3'($urandom);
				c.status_word = 16'($urandom);
				pick = $urandom_range(99);
				if (pick < 3) begin
					c.operation = OP_UNUSED;
				end else if (pick < (fill_trend ? 50 : 20)) begin
					c.operation = OP_POST;
				end else if (pick < (fill_trend ? 80 : 32)) begin
					c.operation = OP_SNAPSHOT;
					// Often start from a healthy status and break at most one condition.
					if ($urandom_range(1) == 0) begin
						c.status_word = (c.status_word | 16'hE200) & ~16'h1000;
						case ($urandom_range(5))
							0: c.status_word[ST_READY_BIT] = 1'b0;
							1: c.status_word[ST_ARMED_BIT] = 1'b0;
							2: c.status_word[ST_MODE_HI_BIT] = 1'b1;
							3: c.status_word[ST_RUN0_BIT] = 1'b0;
							4: c.status_word[ST_RUN1_BIT] = 1'b0;
							default: ;
						endcase
					end
				end else begin
					c.operation = OP_POP;
				end
				send_word(c, 1'b0, '0);
				sender_pause();
			end
			drain();
			squeeze_on <= 1'b0;
		end

		// Let any stray response show up before the verdict.
		repeat (4) @(posedge clk);
		if (pending_rsp.size() != 0)
			report_mismatch($sformatf("%0d responses never arrived", pending_rsp.size()));

		$display("covered %0d commands, %0d responses, %0d events popped, fill peaked at %0d",
			n_cmds, n_rsps, n_popped, max_fill);
		$display("dropped %0d critical and %0d info events; input held off %0d cycles",
			lost_crit_cnt, lost_info_cnt, held_off_cycles);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/eqrs_pkg.sv
rtl/core/eqrs_cell.sv
rtl/core/eqrs_admit.sv
rtl/core/event_queue_reserved_slots.sv
rtl/core/eqrs_checker.sv
tb/sv/tb_event_queue_reserved_slots.sv
